### rtl/ols_pkg.sv
package ols_pkg;

    // Fixed field widths of the request and response beats
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    // Which data goes into result_value / position
    typedef enum logic [1:0] {
        RSP_PLAIN   = 2'd0,  // both zero
        RSP_POP     = 2'd1,  // oldest value, position zero
        RSP_FOUND   = 2'd2,  // scan index, value zero
        RSP_REMOVED = 2'd3   // scan index and the matching value
    } t_rsp_kind;

    // Controller -> datapath
    typedef struct packed {
        logic      capture;     // latch search key, clear scan index
        logic      step;        // advance scan index
        logic      push;        // shift cells up, insert at newest end
        logic      pop;         // drop oldest
        logic      remove_hit;  // close the gap at the scan index
        logic      write_rsp;   // load the response register
        t_status   status;
        t_rsp_kind kind;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic match;  // cell at scan index equals key
        logic last;   // scan index is the oldest held entry
    } t_dp_stat;

endpackage

### rtl/ols_if.sv
interface ols_req_if;
    logic                               valid;
    logic                               ready;
    logic        [ols_pkg::CMD_W-1:0]   cmd;
    logic signed [ols_pkg::VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ols_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [ols_pkg::STATUS_W-1:0] status;
    logic signed [ols_pkg::VALUE_W-1:0]  result_value;
    logic        [ols_pkg::POS_W-1:0]    position;
    logic        [ols_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output status, output result_value,
                    output position, output count, input ready);
    modport sink   (input valid, input status, input result_value,
                    input position, input count, output ready);
endinterface

### rtl/ols_ctrl.sv
module ols_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic [ols_pkg::CMD_W-1:0] i_req_cmd,
    output logic                      o_req_ready,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    input  ols_pkg::t_dp_stat         i_stat,
    output ols_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   r_is_remove, n_is_remove;

    always_comb begin
        n_state     = r_state;
        n_is_remove = r_is_remove;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_req_ready = 1'b0;

        o_cmd.capture    = 1'b0;
        o_cmd.step       = 1'b0;
        o_cmd.push       = 1'b0;
        o_cmd.pop        = 1'b0;
        o_cmd.remove_hit = 1'b0;
        o_cmd.write_rsp  = 1'b0;
        o_cmd.status     = ols_pkg::STATUS_OK;
        o_cmd.kind       = ols_pkg::RSP_PLAIN;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = !r_rsp_valid || i_rsp_ready;
                if (o_req_ready && i_req_valid) begin
                    case (ols_pkg::t_cmd'(i_req_cmd))
                        ols_pkg::CMD_PUSH: begin
                            o_cmd.write_rsp = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.status = ols_pkg::STATUS_FULL;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        ols_pkg::CMD_POP: begin
                            o_cmd.write_rsp = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.status = ols_pkg::STATUS_EMPTY;
                            end else begin
                                o_cmd.pop  = 1'b1;
                                o_cmd.kind = ols_pkg::RSP_POP;
                            end
                        end
                        ols_pkg::CMD_REMOVE: begin
                            if (i_stat.empty) begin
                                o_cmd.write_rsp = 1'b1;
                                o_cmd.status    = ols_pkg::STATUS_EMPTY;
                            end else begin
                                o_cmd.capture = 1'b1;
                                n_is_remove   = 1'b1;
                                n_state       = ST_SCAN;
                            end
                        end
                        ols_pkg::CMD_SEARCH: begin
                            if (i_stat.empty) begin
                                o_cmd.write_rsp = 1'b1;
                                o_cmd.status    = ols_pkg::STATUS_NOT_FOUND;
                            end else begin
                                o_cmd.capture = 1'b1;
                                n_is_remove   = 1'b0;
                                n_state       = ST_SCAN;
                            end
                        end
                        default: begin
                            o_cmd.write_rsp = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.write_rsp = 1'b1;
                    n_state         = ST_IDLE;
                    if (r_is_remove) begin
                        o_cmd.remove_hit = 1'b1;
                        o_cmd.kind       = ols_pkg::RSP_REMOVED;
                    end else begin
                        o_cmd.kind = ols_pkg::RSP_FOUND;
                    end
                end else if (i_stat.last) begin
                    o_cmd.write_rsp = 1'b1;
                    o_cmd.status    = ols_pkg::STATUS_NOT_FOUND;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.write_rsp) begin
            n_rsp_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
            r_is_remove <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_is_remove <= n_is_remove;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

### rtl/ols_dp.sv
module ols_dp #(
    parameter int DEPTH      = ols_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ols_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [ols_pkg::VALUE_W-1:0] i_value,
    input  ols_pkg::t_dp_cmd                   i_cmd,
    output ols_pkg::t_dp_stat                  o_stat,
    output logic [ols_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ols_pkg::VALUE_W-1:0] o_result_value,
    output logic [ols_pkg::POS_W-1:0]          o_position,
    output logic [ols_pkg::COUNT_W-1:0]        o_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // cells[0] is the newest entry
    logic signed [DATA_WIDTH-1:0] r_cells [DEPTH];
    logic [CNT_W-1:0]             r_count, n_count;
    logic [IDX_W-1:0]             r_idx;
    logic signed [DATA_WIDTH-1:0] r_key;

    logic [ols_pkg::STATUS_W-1:0]       r_status;
    logic signed [ols_pkg::VALUE_W-1:0] r_rval;
    logic [ols_pkg::POS_W-1:0]          r_pos;
    logic [ols_pkg::COUNT_W-1:0]        r_rsp_count;

    logic signed [DATA_WIDTH-1:0] w_key_in;
    logic signed [DATA_WIDTH-1:0] w_tail;
    logic signed [DATA_WIDTH-1:0] w_scan;
    logic signed [DATA_WIDTH-1:0] w_rval;
    logic [ols_pkg::POS_W-1:0]    w_pos;

    assign w_key_in = DATA_WIDTH'(i_value);
    assign w_tail   = r_cells[IDX_W'(r_count - CNT_W'(1))];
    assign w_scan   = r_cells[r_idx];

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.match = (w_scan == r_key);
    assign o_stat.last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop || i_cmd.remove_hit) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.kind)
            ols_pkg::RSP_POP:     w_rval = w_tail;
            ols_pkg::RSP_REMOVED: w_rval = w_scan;
            default:              w_rval = '0;
        endcase
        if (i_cmd.kind == ols_pkg::RSP_FOUND || i_cmd.kind == ols_pkg::RSP_REMOVED) begin
            w_pos = ols_pkg::POS_W'(r_idx);
        end else begin
            w_pos = '0;
        end
    end

    // Shift chain: push moves every cell up one, remove pulls cells
    // above the hit down one.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] w_below;
        logic signed [DATA_WIDTH-1:0] w_above;
        logic                         w_pull;

        if (k == 0) begin : g_first
            assign w_below = w_key_in;
        end else begin : g_rest
            assign w_below = r_cells[k-1];
        end

        if (k < DEPTH - 1) begin : g_pull
            assign w_above = r_cells[k+1];
            assign w_pull  = i_cmd.remove_hit && (IDX_W'(k) >= r_idx);
        end else begin : g_top
            assign w_above = r_cells[k];
            assign w_pull  = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.push) begin
                r_cells[k] <= w_below;
            end else if (w_pull) begin
                r_cells[k] <= w_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= w_key_in;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.write_rsp) begin
            r_status    <= i_cmd.status;
            r_rval      <= ols_pkg::VALUE_W'(w_rval);
            r_pos       <= w_pos;
            r_rsp_count <= ols_pkg::COUNT_W'(n_count);
        end
    end

    assign o_status       = r_status;
    assign o_result_value = r_rval;
    assign o_position     = r_pos;
    assign o_count        = r_rsp_count;

endmodule

### rtl/ordered_list_store.sv
// Push and pop answer from the response register, which loads at accept.
// Remove and search scan one cell per cycle from the newest end until a hit or
// the oldest held entry; on an empty store they answer at accept as well.
// One beat at a time: the next request is taken when the response slot frees,
// and no request is taken while a scan runs.
// Reset (i_rst_n low, synchronous): count and handshake state cleared; cells keep data.
module ordered_list_store #(
    parameter int DEPTH      = ols_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ols_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ols_req_if.sink    i_req,
    ols_rsp_if.source  o_rsp
);

    // Command and status bundles between the sequencer and the cell chain
    ols_pkg::t_dp_cmd  w_cmd;
    ols_pkg::t_dp_stat w_stat;

    // Sequencer: takes a request beat, decides between an immediate answer
    // (push, pop, anything on an empty store) and a scan, and owns the
    // response valid. A new request beat is taken in the same cycle the
    // waiting response beat leaves.
    ols_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (i_req.cmd),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Cell chain: newest at index 0. Push shifts the chain up, remove closes
    // the gap above the hit, pop only drops the fill count. The scan compares
    // one cell per cycle against the latched key.
    ols_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_req.value),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_status       (o_rsp.status),
        .o_result_value (o_rsp.result_value),
        .o_position     (o_rsp.position),
        .o_count        (o_rsp.count)
    );

endmodule

### rtl/ols_checker.sv
module ols_checker #(
    parameter int DEPTH = ols_pkg::DEPTH_DEFAULT
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic [ols_pkg::STATUS_W-1:0]       i_rsp_status,
    input logic signed [ols_pkg::VALUE_W-1:0] i_rsp_result_value,
    input logic [ols_pkg::POS_W-1:0]          i_rsp_position,
    input logic [ols_pkg::COUNT_W-1:0]        i_rsp_count
);

    // A stalled response beat stays up
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    // No response beat right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A refused push only happens at the fill limit
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ols_pkg::STATUS_FULL
            |-> i_rsp_count == ols_pkg::COUNT_W'(DEPTH))
        else $error("full status with store not full");

    // Empty status means nothing held and nothing returned
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ols_pkg::STATUS_EMPTY
            |-> i_rsp_count == '0 && i_rsp_result_value == '0)
        else $error("empty status with data");

    // Failed operations carry no position
    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ols_pkg::STATUS_OK |-> i_rsp_position == '0)
        else $error("position set on failed operation");

endmodule

bind ordered_list_store ols_checker #(
    .DEPTH (DEPTH)
) u_ols_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_result_value (o_rsp.result_value),
    .i_rsp_position     (o_rsp.position),
    .i_rsp_count        (o_rsp.count)
);

### test/ordered_list_store_tb.sv
`timescale 1ns / 1ps

module ordered_list_store_tb;

    localparam int LIST_DEPTH   = ols_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1900;
    localparam int MIX_SPAN     = 120;   // items per stimulus mix phase
    localparam int DRAIN_CYCLES = 40;    // idle tail after the last response; a scan covers at most depth cells

    // One response beat as the predictor sees it
    typedef struct packed {
        ols_pkg::t_status status;
        logic [31:0]      rval;
        logic [3:0]       pos;
        logic [4:0]       count;
    } t_list_rsp;

    // Directed stimulus row; rsp is only used when typed is set
    typedef struct packed {
        ols_pkg::t_cmd cmd;
        logic [31:0]   value;
        logic [4:0]    reps;    // repeated rows bump value by one per beat
        logic          typed;
        t_list_rsp     rsp;
    } t_dir_row;

    // Random command mixes: fill toward full, drain toward empty, or even
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    localparam t_dir_row DIRECTED_ROWS [0:20] = '{
        // empty store: every command that needs data is refused
        '{ols_pkg::CMD_POP,    32'h0000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_EMPTY,     32'h0, 4'd0, 5'd0}},
        '{ols_pkg::CMD_REMOVE, 32'h0000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_EMPTY,     32'h0, 4'd0, 5'd0}},
        '{ols_pkg::CMD_SEARCH, 32'h0000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_NOT_FOUND, 32'h0, 4'd0, 5'd0}},
        // value extremes, with a duplicate of the most negative word
        '{ols_pkg::CMD_PUSH,   32'h7FFF_FFFF, 5'd1,  1'b1,
          '{ols_pkg::STATUS_OK,        32'h0, 4'd0, 5'd1}},
        '{ols_pkg::CMD_PUSH,   32'h8000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_OK,        32'h0, 4'd0, 5'd2}},
        '{ols_pkg::CMD_PUSH,   32'h0000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_OK,        32'h0, 4'd0, 5'd3}},
        '{ols_pkg::CMD_PUSH,   32'hFFFF_FFFF, 5'd1,  1'b1,
          '{ols_pkg::STATUS_OK,        32'h0, 4'd0, 5'd4}},
        '{ols_pkg::CMD_PUSH,   32'h8000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_OK,        32'h0, 4'd0, 5'd5}},
        // search: duplicate hits the newest copy, oldest entry, miss
        '{ols_pkg::CMD_SEARCH, 32'h8000_0000, 5'd1,  1'b0, '0},
        '{ols_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 5'd1,  1'b0, '0},
        '{ols_pkg::CMD_SEARCH, 32'h0000_0005, 5'd1,  1'b0, '0},
        // remove at head, at tail, then a miss
        '{ols_pkg::CMD_REMOVE, 32'h8000_0000, 5'd1,  1'b0, '0},
        '{ols_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 5'd1,  1'b0, '0},
        '{ols_pkg::CMD_REMOVE, 32'h0000_3039, 5'd1,  1'b1,
          '{ols_pkg::STATUS_NOT_FOUND, 32'h0, 4'd0, 5'd3}},
        // pop after a tail remove; its value field is don't-care
        '{ols_pkg::CMD_POP,    32'hDEAD_BEEF, 5'd1,  1'b0, '0},
        // fill to the brim, then one push too many
        '{ols_pkg::CMD_PUSH,   32'h0000_0064, 5'd14, 1'b0, '0},
        '{ols_pkg::CMD_PUSH,   32'h0000_03E7, 5'd1,  1'b1,
          '{ols_pkg::STATUS_FULL,      32'h0, 4'd0, 5'd16}},
        '{ols_pkg::CMD_SEARCH, 32'h0000_0064, 5'd1,  1'b0, '0},
        '{ols_pkg::CMD_REMOVE, 32'h0000_0071, 5'd1,  1'b0, '0},
        // drain everything, then pop once more
        '{ols_pkg::CMD_POP,    32'h0000_0000, 5'd15, 1'b0, '0},
        '{ols_pkg::CMD_POP,    32'h0000_0000, 5'd1,  1'b1,
          '{ols_pkg::STATUS_EMPTY,     32'h0, 4'd0, 5'd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ols_req_if req_bus ();
    ols_rsp_if rsp_bus ();

    ordered_list_store #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (ols_pkg::DATA_WIDTH_DEFAULT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the list: slot 0 is newest, slots below list_count are live
    logic [31:0] list_cells [LIST_DEPTH];
    int unsigned list_count;

    t_list_rsp   pending_rsp [$];   // responses still owed by the DUT, oldest first
    int unsigned fail_count;
    bit          calm;              // no idle cycles on either side this phase

    // Apply one command to the shadow list and return the response it owes.
    // Lookups scan from the newest end, so duplicates resolve to the newest copy.
    function automatic t_list_rsp apply_cmd(ols_pkg::t_cmd cmd, logic [31:0] val);
        t_list_rsp r;
        int        hit;
        int        i;
        r        = '0;
        r.status = ols_pkg::STATUS_OK;
        hit      = -1;
        for (i = 0; i < int'(list_count); i++) begin
            if (hit < 0 && list_cells[i] == val) begin
                hit = i;
            end
        end
        case (cmd)
            ols_pkg::CMD_PUSH: begin
                if (list_count >= LIST_DEPTH) begin
                    r.status = ols_pkg::STATUS_FULL;
                end else begin
                    for (i = int'(list_count); i > 0; i--) begin
                        list_cells[i] = list_cells[i-1];
                    end
                    list_cells[0] = val;
                    list_count++;
                end
            end
            ols_pkg::CMD_POP: begin
                if (list_count == 0) begin
                    r.status = ols_pkg::STATUS_EMPTY;
                end else begin
                    r.rval = list_cells[list_count-1];
                    list_count--;
                end
            end
            ols_pkg::CMD_REMOVE: begin
                if (list_count == 0) begin
                    r.status = ols_pkg::STATUS_EMPTY;
                end else if (hit < 0) begin
                    r.status = ols_pkg::STATUS_NOT_FOUND;
                end else begin
                    r.rval = list_cells[hit];
                    r.pos  = hit[3:0];
                    for (i = hit; i + 1 < int'(list_count); i++) begin
                        list_cells[i] = list_cells[i+1];
                    end
                    list_count--;
                end
            end
            default: begin  // search
                if (hit < 0) begin
                    r.status = ols_pkg::STATUS_NOT_FOUND;
                end else begin
                    r.pos = hit[3:0];
                end
            end
        endcase
        r.count = list_count[4:0];
        return r;
    endfunction

    // Command draw, weighted by the current mix
    function automatic ols_pkg::t_cmd pick_cmd(t_mix mix);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned rem_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_pct = 55; pop_pct = 10; rem_pct = 15; end
            MIX_DRAIN: begin push_pct = 15; pop_pct = 35; rem_pct = 30; end
            default:   begin push_pct = 30; pop_pct = 20; rem_pct = 25; end
        endcase
        if (roll < push_pct) begin
            return ols_pkg::CMD_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            return ols_pkg::CMD_POP;
        end else if (roll < push_pct + pop_pct + rem_pct) begin
            return ols_pkg::CMD_REMOVE;
        end
        return ols_pkg::CMD_SEARCH;
    endfunction

    // Value draw: half the time a word already held so remove/search hit,
    // a small pool to breed duplicates, the extremes, and full-range noise
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5 && list_count > 0) begin
            return list_cells[$urandom_range(0, list_count - 1)];
        end else if (roll < 7) begin
            return 32'($signed($urandom_range(0, 7)) - 4);
        end else if (roll == 7) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Drive one request beat. Called at a falling edge; returns at the falling
    // edge after the beat is taken. valid only drops when a gap is drawn, so
    // back-to-back beats keep it high with a single assignment per step.
    task automatic send_req(input ols_pkg::t_cmd cmd, input logic [31:0] val,
                            input logic typed, input t_list_rsp typed_rsp);
        int        gap;
        t_list_rsp owed;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.cmd   <= cmd;
        req_bus.value <= val;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        // the predictor always runs so its state tracks the DUT
        owed = apply_cmd(cmd, val);
        if (typed) begin
            owed = typed_rsp;
        end
        pending_rsp.push_back(owed);
        @(negedge i_clk);
    endtask

    // Response side: hold ready low for a random stall drawn per beat (none when calm), then wait for it
    initial begin
        int stall;
        rsp_bus.ready <= 1'b0;
        do @(negedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // Scoreboard: every response beat against the oldest owed response
    always @(posedge i_clk) begin
        t_list_rsp want;
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: response beat with none owed (status %0d count %0d)",
                         $time, rsp_bus.status, rsp_bus.count);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.result_value !== want.rval) begin
                    $display("%0t: result_value expected %h got %h",
                             $time, want.rval, rsp_bus.result_value);
                    fail_count++;
                end
                if (rsp_bus.position !== want.pos) begin
                    $display("%0t: position expected %0d got %0d",
                             $time, want.pos, rsp_bus.position);
                    fail_count++;
                end
                if (rsp_bus.count !== want.count) begin
                    $display("%0t: count expected %0d got %0d",
                             $time, want.count, rsp_bus.count);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random mix phases, drain
    initial begin
        t_dir_row row;
        t_mix     mix;
        int       k;
        int       n;
        i_rst_n       <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.cmd   <= ols_pkg::CMD_PUSH;
        req_bus.value <= '0;
        list_count    = 0;
        fail_count    = 0;
        calm          = 1'b0;
        mix           = MIX_EVEN;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < $size(DIRECTED_ROWS); n++) begin
            row = DIRECTED_ROWS[n];
            for (k = 0; k < int'(row.reps); k++) begin
                send_req(row.cmd, row.value + 32'(k), row.typed, row.rsp);
            end
        end

        // Mix and idling change every phase; roughly a quarter of the
        // phases run with no idle cycles to get full-rate back-to-back beats
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % MIX_SPAN == 0) begin
                case ($urandom_range(0, 2))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_EVEN;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            send_req(pick_cmd(mix), pick_value(), 1'b0, '0);
        end
        req_bus.valid <= 1'b0;

        while (pending_rsp.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
